[hdl/assert_macros.svh]
// assertion macros used by the reassembler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/prxr_pkg.sv]
// package: constants, codes and types of the proxy pdu reassembler
package prxr_pkg;

  localparam int BUF_BYTES = 64;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);
  localparam int PLEN_W    = 7;
  localparam int CMP_W     = ((CNT_W > PLEN_W) ? CNT_W : PLEN_W) + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NETWORK_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEACON_EN  = 1'd1;

  localparam logic [1:0] SAR_COMPLETE = 2'd0;
  localparam logic [1:0] SAR_FIRST    = 2'd1;
  localparam logic [1:0] SAR_CONTINUE = 2'd2;
  localparam logic [1:0] SAR_LAST     = 2'd3;

  localparam logic [5:0] TYPE_NETWORK = 6'd0;
  localparam logic [5:0] TYPE_BEACON  = 6'd1;

  localparam logic ACT_SEGMENT = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_READY    = 3'd1;
  localparam logic [2:0] ST_REJECT   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } buf_ctl_t;

endpackage

[hdl/prxr_buf.sv]
// message byte buffer: one write port, one registered read port
module prxr_buf
  import prxr_pkg::*;
(
  input  logic     clk,
  input  buf_ctl_t ctl,
  output logic [7:0] rd_data
);

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/proxy_pdu_reassembler_top.sv]
// result: a result is registered and presented in the cycle after its input transaction is accepted
// throughput: one transaction per cycle; in_stall rises only while a result is held
//   by out_stall, so the output register sets the pace
// reset: synchronous active-low rst_n clears enables, segment state, counters and
//   output valid; the message buffer is not cleared and holds garbage until written
module proxy_pdu_reassembler_top
  import prxr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_starts_segment,
  input  logic [PLEN_W-1:0]     in_segment_payload_len,
  input  logic                  in_ends_segment,
  input  logic [5:0]            in_read_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic                  out_message_type,
  output logic [6:0]            out_message_length,
  output logic [7:0]            out_read_data
);

`include "assert_macros.svh"

  logic             net_en_r;
  logic             bcn_en_r;
  logic [CNT_W-1:0] fill_r,   fill_nxt;
  logic [1:0]       sar_r,    sar_nxt;
  logic             styp_r,   styp_nxt;
  logic             sacc_r,   sacc_nxt;
  logic [CNT_W-1:0] wptr_r,   wptr_nxt;
  logic [CNT_W-1:0] dlen_r,   dlen_nxt;
  logic             dtyp_r,   dtyp_nxt;
  logic             out_valid_r;
  logic [2:0]       status_r, status_nxt;
  logic             rd_ok_r,  rd_ok_nxt;

  logic             accept;
  buf_ctl_t         bctl;
  logic [7:0]       buf_q;

  logic [1:0]       hdr_sar;
  logic [5:0]       hdr_type;
  logic             type_ok;
  logic [CNT_W-1:0] base;
  logic [CMP_W-1:0] room;
  logic [CMP_W-1:0] plen_ext;
  logic [CMP_W-1:0] end_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;

  assign hdr_sar  = in_data_byte[7:6];
  assign hdr_type = in_data_byte[5:0];
  assign type_ok  = ((hdr_type == TYPE_NETWORK) && net_en_r) ||
                    ((hdr_type == TYPE_BEACON) && bcn_en_r);
  assign base     = ((hdr_sar == SAR_FIRST) || (hdr_sar == SAR_COMPLETE)) ? '0 : fill_r;
  assign room     = CMP_W'(BUF_BYTES) - CMP_W'(base);
  assign plen_ext = CMP_W'(in_segment_payload_len);
  assign end_ext  = CMP_W'(base) + plen_ext;

  always_comb begin
    fill_nxt   = fill_r;
    sar_nxt    = sar_r;
    styp_nxt   = styp_r;
    sacc_nxt   = sacc_r;
    wptr_nxt   = wptr_r;
    dlen_nxt   = dlen_r;
    dtyp_nxt   = dtyp_r;
    status_nxt = ST_OK;
    rd_ok_nxt  = 1'b0;
    bctl.wr_en   = 1'b0;
    bctl.wr_addr = fill_r[ADDR_W-1:0];
    bctl.wr_data = in_data_byte;
    bctl.rd_en   = accept && (in_action == ACT_READ);
    bctl.rd_addr = ADDR_W'(in_read_index);

    if (in_action == ACT_READ) begin
      status_nxt = ST_READ;
      rd_ok_nxt  = (CMP_W'(in_read_index) < CMP_W'(dlen_r)) &&
                   (CMP_W'(in_read_index) < CMP_W'(BUF_BYTES));
    end else begin
      if (in_starts_segment) begin
        sacc_nxt = 1'b0;
        if (!type_ok) begin
          status_nxt = ST_REJECT;
        end else if (plen_ext > room) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          sacc_nxt = 1'b1;
          sar_nxt  = hdr_sar;
          styp_nxt = hdr_type[0];
          fill_nxt = base;
          wptr_nxt = CNT_W'(end_ext);
        end
      end else if (sacc_r && (fill_r < wptr_r) && (fill_r < CNT_W'(BUF_BYTES))) begin
        bctl.wr_en = accept;
        fill_nxt   = fill_r + CNT_W'(1);
      end
      if (in_ends_segment && sacc_nxt) begin
        sacc_nxt = 1'b0;
        if ((sar_nxt == SAR_LAST) || (sar_nxt == SAR_COMPLETE)) begin
          dlen_nxt   = fill_nxt;
          dtyp_nxt   = styp_nxt;
          fill_nxt   = '0;
          status_nxt = ST_READY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_en_r <= 1'b0;
      bcn_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NETWORK_EN: net_en_r <= cfg_wdata[0];
        REG_BEACON_EN:  bcn_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      sar_r       <= SAR_COMPLETE;
      styp_r      <= 1'b0;
      sacc_r      <= 1'b0;
      wptr_r      <= '0;
      dlen_r      <= '0;
      dtyp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r <= fill_nxt;
        sar_r  <= sar_nxt;
        styp_r <= styp_nxt;
        sacc_r <= sacc_nxt;
        wptr_r <= wptr_nxt;
        dlen_r <= dlen_nxt;
        dtyp_r <= dtyp_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rd_ok_r  <= rd_ok_nxt;
    end
  end

  prxr_buf u_buf (
    .clk     (clk),
    .ctl     (bctl),
    .rd_data (buf_q)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_message_type   = dtyp_r;
  assign out_message_length = 7'(dlen_r);
  assign out_read_data      = rd_ok_r ? buf_q : 8'd0;

  `ASSERT_ALWAYS(a_fill_in_range, fill_r <= CNT_W'(BUF_BYTES), "fill count past buffer size")
  `ASSERT_IMPLIES(a_fill_below_end, sacc_r, fill_r <= wptr_r, "fill count past segment end")
  `ASSERT_IMPLIES(a_ready_closes, out_valid_r && (status_r == ST_READY), !sacc_r && (fill_r == '0), "segment left open after delivery")
  `ASSERT_IMPLIES(a_read_in_len, out_valid_r && rd_ok_r, (status_r == ST_READ) && (dlen_r != '0), "read data enabled outside a read")

endmodule

[tb/proxy_pdu_reassembler_top_tb.sv]
// self-checking testbench of the proxy pdu reassembler: directed and random segment and read traffic
module proxy_pdu_reassembler_top_tb
  import prxr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT   = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic              action;
    logic [7:0]        data_byte;
    logic              starts;
    logic [PLEN_W-1:0] plen;
    logic              ends;
    logic [5:0]        read_index;
  } pdu_byte_t;

  typedef struct packed {
    logic [2:0] status;
    logic       pdu_kind;
    logic [6:0] msg_len;
    logic [7:0] rd_data;
  } pdu_result_t;

  class reassembly_checker;
    bit          net_en;
    bit          bcn_en;
    logic [7:0]  msg_buf [BUF_BYTES];
    int unsigned fill;
    int unsigned seg_end;
    logic [1:0]  open_sar;
    logic        open_type;
    bit          open_ok;
    int unsigned dlv_len;
    logic        dlv_type;
    pdu_result_t awaited[$];
    int          errors;

    function new();
      foreach (msg_buf[i]) msg_buf[i] = 8'h00;
      net_en = 0;
      bcn_en = 0;
      fill = 0;
      seg_end = 0;
      open_sar = SAR_COMPLETE;
      open_type = 1'b0;
      open_ok = 0;
      dlv_len = 0;
      dlv_type = 1'b0;
      errors = 0;
    endfunction

    function void note_accepted_byte(pdu_byte_t b);
      pdu_result_t r;
      logic [1:0]  sar;
      logic [5:0]  typ;
      int unsigned base;
      r.status = ST_OK;
      r.rd_data = 8'h00;
      if (b.action == ACT_READ) begin
        r.status = ST_READ;
        if (b.read_index < dlv_len) r.rd_data = msg_buf[b.read_index];
      end else begin
        if (b.starts) begin
          sar = b.data_byte[7:6];
          typ = b.data_byte[5:0];
          base = (sar == SAR_FIRST || sar == SAR_COMPLETE) ? 0 : fill;
          open_ok = 0;
          if (!((typ == TYPE_NETWORK && net_en) || (typ == TYPE_BEACON && bcn_en))) begin
            r.status = ST_REJECT;
          end else if (b.plen > BUF_BYTES - base) begin
            r.status = ST_OVERFLOW;
          end else begin
            open_ok = 1;
            open_sar = sar;
            open_type = typ[0];
            fill = base;
            seg_end = base + b.plen;
          end
        end else if (open_ok && fill < seg_end && fill < BUF_BYTES) begin
          msg_buf[fill] = b.data_byte;
          fill++;
        end
        if (b.ends && open_ok) begin
          open_ok = 0;
          if (open_sar == SAR_LAST || open_sar == SAR_COMPLETE) begin
            dlv_len = fill;
            dlv_type = open_type;
            fill = 0;
            r.status = ST_READY;
          end
        end
      end
      r.pdu_kind = dlv_type;
      r.msg_len = dlv_len[6:0];
      awaited.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [2:0] status, logic mtype, logic [6:0] mlen, logic [7:0] rdata);
      pdu_result_t want;
      if (awaited.size() == 0) begin
        report("unexpected result status", status, 0);
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status) report("status", status, want.status);
      if (mtype !== want.pdu_kind) report("message_type", mtype, want.pdu_kind);
      if (mlen !== want.msg_len) report("message_length", mlen, want.msg_len);
      if (rdata !== want.rd_data) report("read_data", rdata, want.rd_data);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_NETWORK_EN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = ACT_SEGMENT;
  logic [7:0]            in_data_byte = 8'h00;
  logic                  in_starts_segment = 1'b0;
  logic [PLEN_W-1:0]     in_segment_payload_len = '0;
  logic                  in_ends_segment = 1'b0;
  logic [5:0]            in_read_index = 6'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  logic [2:0]            out_status;
  logic                  out_message_type;
  logic [6:0]            out_message_length;
  logic [7:0]            out_read_data;

  reassembly_checker sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int items_sent = 0;
  int cycles = 0;

  proxy_pdu_reassembler_top DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("proxy_pdu_reassembler_top_tb failed");
      $finish;
    end
  end

  initial begin : result_side
    int hold_left;
    int served;
    hold_left = 0;
    served = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_status, out_message_type, out_message_length, out_read_data);
      if (served != hold_requests) begin
        served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic pdu_byte_t mk_seg(logic [7:0] data, logic starts, int plen, logic ends);
    pdu_byte_t b;
    b.action = ACT_SEGMENT;
    b.data_byte = data;
    b.starts = starts;
    b.plen = PLEN_W'(plen);
    b.ends = ends;
    b.read_index = 6'($urandom_range(63));
    return b;
  endfunction

  function automatic pdu_byte_t mk_read(int idx);
    pdu_byte_t b;
    b.action = ACT_READ;
    b.data_byte = 8'($urandom_range(255));
    b.starts = 1'($urandom_range(1));
    b.plen = PLEN_W'($urandom_range(127));
    b.ends = 1'($urandom_range(1));
    b.read_index = 6'(idx);
    return b;
  endfunction

  task automatic send(input pdu_byte_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= b.action;
    in_data_byte <= b.data_byte;
    in_starts_segment <= b.starts;
    in_segment_payload_len <= b.plen;
    in_ends_segment <= b.ends;
    in_read_index <= b.read_index;
    do @(posedge clk); while (in_stall);
    sb.note_accepted_byte(b);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_enables(input bit net, input bit bcn);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_NETWORK_EN;
    cfg_wdata <= CFG_DATA_W'(net);
    @(posedge clk);
    cfg_index <= REG_BEACON_EN;
    cfg_wdata <= CFG_DATA_W'(bcn);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.net_en = net;
    sb.bcn_en = bcn;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(6);
    if (r < 95) return $urandom_range(BUF_BYTES);
    return $urandom_range(127, BUF_BYTES + 1);
  endfunction

  function automatic logic [5:0] pick_type();
    int r;
    r = $urandom_range(99);
    if (r < 45) return TYPE_NETWORK;
    if (r < 90) return TYPE_BEACON;
    return 6'($urandom_range(63, 2));
  endfunction

  task automatic send_segment(input logic [1:0] sar, input logic [5:0] typ, input int plen);
    int n;
    int shape;
    bit closes;
    n = plen;
    shape = $urandom_range(99);
    if (shape < 6 && plen > 0) n = $urandom_range(plen - 1);
    closes = !(shape >= 6 && shape < 10);
    send(mk_seg({sar, typ}, 1'b1, plen, closes && n == 0));
    for (int i = 0; i < n; i++)
      send(mk_seg(8'($urandom_range(255)), 1'b0, $urandom_range(127), closes && i == n - 1));
    if (shape >= 10 && shape < 14)
      repeat ($urandom_range(1, 2))
        send(mk_seg(8'($urandom_range(255)), 1'b0, $urandom_range(127), 1'b0));
  endtask

  task automatic send_message();
    logic [5:0] typ;
    typ = pick_type();
    if ($urandom_range(99) < 40) begin
      send_segment(SAR_COMPLETE, typ, pick_len());
    end else begin
      send_segment(SAR_FIRST, typ, pick_len());
      repeat ($urandom_range(3)) send_segment(SAR_CONTINUE, typ, pick_len());
      send_segment(SAR_LAST, typ, pick_len());
    end
    repeat ($urandom_range(3)) begin
      if (sb.dlv_len > 0 && $urandom_range(99) < 75) send(mk_read($urandom_range(sb.dlv_len - 1)));
      else send(mk_read($urandom_range(63)));
    end
  endtask

  task automatic run_phase(input int budget);
    int first;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(99) < 12) begin
        if ($urandom_range(1)) send(mk_read($urandom_range(63)));
        else send(mk_seg(8'($urandom_range(255)), 1'($urandom_range(1)),
                         $urandom_range(127), 1'($urandom_range(1))));
      end else begin
        send_message();
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // enables still at reset
    send(mk_read(0));
    send(mk_seg(8'h00, 1'b1, 0, 1'b1));
    drain();
    set_enables(1'b1, 1'b0);

    send(mk_seg(8'h00, 1'b1, 2, 1'b0));
    send(mk_seg(8'hFF, 1'b0, 0, 1'b0));
    send(mk_seg(8'h00, 1'b0, 0, 1'b1));
    send(mk_read(1));
    send(mk_read(2));
    send(mk_seg(8'h01, 1'b1, 0, 1'b1));
    send(mk_seg(8'h7F, 1'b1, 3, 1'b0));
    send(mk_seg(8'h40, 1'b1, 127, 1'b0));
    send(mk_seg(8'hA5, 1'b0, 0, 1'b0));
    send(mk_seg(8'h40, 1'b1, 3, 1'b0));
    send(mk_seg(8'h11, 1'b0, 0, 1'b0));
    send(mk_seg(8'h22, 1'b0, 0, 1'b0));
    send(mk_seg(8'h33, 1'b0, 0, 1'b0));
    // past the declared length
    send(mk_seg(8'h44, 1'b0, 0, 1'b0));
    send(mk_seg(8'h80, 1'b1, 62, 1'b0));
    send(mk_seg(8'h80, 1'b1, 61, 1'b1));
    send(mk_seg(8'hC0, 1'b1, 1, 1'b0));
    send(mk_seg(8'h55, 1'b0, 0, 1'b1));
    send(mk_read(3));
    send(mk_read(63));
    send(mk_seg(8'h00, 1'b1, 4, 1'b0));
    send(mk_seg(8'h66, 1'b0, 0, 1'b0));
    send(mk_seg(8'h40, 1'b1, 2, 1'b1));
    send(mk_seg(8'h00, 1'b1, 5, 1'b0));
    send(mk_seg(8'h77, 1'b0, 0, 1'b1));
    send(mk_seg(8'hC0, 1'b1, 1, 1'b0));
    send(mk_seg(8'h88, 1'b0, 0, 1'b1));
    drain();

    set_enables(1'b1, 1'b1);
    send_idle_pct = 10;
    recv_idle_pct = 62;
    run_phase(410);
    drain();

    set_enables(1'b0, 1'b1);
    send_idle_pct = 62;
    recv_idle_pct = 10;
    run_phase(410);
    drain();

    set_enables(1'b1, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(170);
    // long receiver hold-off while transactions keep coming
    hold_requests++;
    run_phase(220);
    drain();

    set_enables(1'b0, 1'b0);
    send_idle_pct = 10;
    recv_idle_pct = 62;
    run_phase(70);
    drain();

    set_enables(1'b1, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(70);
    drain();

    if (sb.errors == 0) begin
      $display("proxy_pdu_reassembler_top_tb passed");
    end else begin
      $display("proxy_pdu_reassembler_top_tb failed");
    end
    $finish;
  end

endmodule
